// ----- rtl/ocs_pkg.sv -----
// ---------------------------------------------------------------------------
// Orbit camera package
// Shared payload types, register indexes, fixed-point constants and the
// CORDIC arctangent table.
// ---------------------------------------------------------------------------
package ocs_pkg;

    localparam int ANGLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CORDIC_ITERS   = 28;
    localparam int ITER_BITS      = 5;

    localparam logic [31:0] STEP_Q32   = 32'd3417826;
    localparam logic [31:0] MARGIN_Q32 = 32'd6835653;
    localparam logic [31:0] ZOOM_Q32   = 32'd429496730;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_LOOK_X     = 3'd0;
    localparam logic [2:0] REG_LOOK_Y     = 3'd1;
    localparam logic [2:0] REG_LOOK_Z     = 3'd2;
    localparam logic [2:0] REG_START_RAD  = 3'd3;
    localparam logic [2:0] REG_START_AZI  = 3'd4;
    localparam logic [2:0] REG_START_ELEV = 3'd5;

    typedef struct packed {
        logic               op;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // apply the step to the angle and radius state
        logic cordic_init; // start both rotations
        logic cordic_step; // one CORDIC iteration
        logic mul_rc;      // radius * cos(e) and radius * sin(e)
        logic mul_out;     // rc * cos(a), rc * sin(a), then add and saturate
    } dp_cmd_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [29:0] atan_entry(input logic [ITER_BITS-1:0] i);
        logic [29:0] r;
        begin
            case (i)
                5'd0:  r = 30'd536870912;
                5'd1:  r = 30'd316933406;
                5'd2:  r = 30'd167458907;
                5'd3:  r = 30'd85004756;
                5'd4:  r = 30'd42667331;
                5'd5:  r = 30'd21354465;
                5'd6:  r = 30'd10679838;
                5'd7:  r = 30'd5340245;
                5'd8:  r = 30'd2670163;
                5'd9:  r = 30'd1335087;
                5'd10: r = 30'd667544;
                5'd11: r = 30'd333772;
                5'd12: r = 30'd166886;
                5'd13: r = 30'd83443;
                5'd14: r = 30'd41722;
                5'd15: r = 30'd20861;
                5'd16: r = 30'd10430;
                5'd17: r = 30'd5215;
                5'd18: r = 30'd2608;
                5'd19: r = 30'd1304;
                5'd20: r = 30'd652;
                5'd21: r = 30'd326;
                5'd22: r = 30'd163;
                5'd23: r = 30'd81;
                5'd24: r = 30'd41;
                5'd25: r = 30'd20;
                5'd26: r = 30'd10;
                5'd27: r = 30'd5;
                default: r = 30'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/ocs_ctrl.sv -----
// ---------------------------------------------------------------------------
// Orbit camera controller
// Sequences one step: state update, CORDIC iterations, two multiply stages
// and the result hand-off.
// ---------------------------------------------------------------------------
module ocs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output ocs_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_ITER = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [ocs_pkg::ITER_BITS-1:0] iter_reg, iter_next;
    logic out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.cordic_init = 1'b1;
                iter_next       = '0;
                state_next      = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.cordic_step = 1'b1;
                iter_next       = iter_reg + 1'b1;
                if (iter_reg == ocs_pkg::ITER_BITS'(ocs_pkg::CORDIC_ITERS - 1))
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul_rc = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                // The output register may still hold the previous result.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.mul_out    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/ocs_datapath.sv -----
// ---------------------------------------------------------------------------
// Orbit camera datapath
// Angle and radius state, two shared-step CORDIC rotators, multipliers and
// saturating output register.
// ---------------------------------------------------------------------------
module ocs_datapath #(
    parameter int ANGLE_BITS = ocs_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = ocs_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ocs_pkg::dp_cmd_t    cmd,
    input  ocs_pkg::in_item_t   in_item,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_idx,
    input  logic [31:0]         cfg_data,
    output logic [31:0]         cfg_rdata_look_x,
    output logic [31:0]         cfg_rdata_look_y,
    output logic [31:0]         cfg_rdata_look_z,
    output logic [31:0]         cfg_rdata_rad,
    output logic [31:0]         cfg_rdata_azi,
    output logic [31:0]         cfg_rdata_elev,
    output ocs_pkg::out_item_t  out_item
);

    localparam int RB = 7 + FRAC_BITS;
    localparam int EB = ANGLE_BITS - 1;
    localparam int ASH = 32 - ANGLE_BITS;
    localparam int ZSH = 32 - FRAC_BITS;
    localparam logic signed [ANGLE_BITS+1:0] ELIM =
        (ANGLE_BITS+2)'((64'sd1 <<< (ANGLE_BITS-2))
        - ((64'sd6835653 + ((64'sd1 <<< ASH) >>> 1)) >>> ASH));
    localparam logic [RB-1:0] RMIN = RB'(64'd1 << FRAC_BITS);
    localparam logic [RB-1:0] RMAX = RB'(64'd100 << FRAC_BITS);

    logic signed [31:0] look_x_reg, look_y_reg, look_z_reg;
    logic [RB-1:0] start_rad_reg, radius_reg;
    logic [ANGLE_BITS-1:0] start_azi_reg, azi_reg;
    logic [EB-1:0] start_elev_reg;
    logic signed [ANGLE_BITS+1:0] elev_reg;

    // Clamp helpers. Both take the full width of a step so that large steps
    // saturate rather than wrap.
    function automatic logic [RB-1:0] clamp_rad(input logic signed [49:0] v);
        begin
            if (v < $signed({2'b00, RMIN}))
                return RMIN;
            else if (v > $signed({2'b00, RMAX}))
                return RMAX;
            else
                return v[RB-1:0];
        end
    endfunction

    function automatic logic signed [ANGLE_BITS+1:0] clamp_elev(
        input logic signed [49:0] v);
        begin
            if (v < -ELIM)
                return -ELIM;
            else if (v > ELIM)
                return ELIM;
            else
                return v[ANGLE_BITS+1:0];
        end
    endfunction

    // Step sizes: products with rounding half up.
    logic signed [49:0] da_prod, de_prod, dr_prod;
    logic signed [49:0] da_r, de_r, dr_r;
    assign da_prod = in_item.delta_x * $signed({1'b0, ocs_pkg::STEP_Q32});
    assign de_prod = in_item.delta_y * $signed({1'b0, ocs_pkg::STEP_Q32});
    assign dr_prod = in_item.delta_y * $signed({1'b0, ocs_pkg::ZOOM_Q32});
    assign da_r = (ASH == 0) ? da_prod : (da_prod + (50'sd1 <<< (ASH-1))) >>> ASH;
    assign de_r = (ASH == 0) ? de_prod : (de_prod + (50'sd1 <<< (ASH-1))) >>> ASH;
    assign dr_r = (ZSH == 0) ? dr_prod : (dr_prod + (50'sd1 <<< (ZSH-1))) >>> ZSH;

    logic signed [49:0] elev_sum;
    logic signed [49:0] rad_diff;
    logic signed [49:0] elev_cfg;
    assign elev_sum = 50'(elev_reg) + de_r;
    assign rad_diff = 50'($signed({2'b00, radius_reg})) - dr_r;
    assign elev_cfg = 50'($signed(cfg_data[EB-1:0]));

    // Configuration registers and step state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            look_x_reg     <= '0;
            look_y_reg     <= '0;
            look_z_reg     <= '0;
            start_rad_reg  <= RB'(64'd5 << FRAC_BITS);
            radius_reg     <= RB'(64'd5 << FRAC_BITS);
            start_azi_reg  <= '0;
            azi_reg        <= '0;
            start_elev_reg <= '0;
            elev_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                ocs_pkg::REG_LOOK_X: look_x_reg <= cfg_data;
                ocs_pkg::REG_LOOK_Y: look_y_reg <= cfg_data;
                ocs_pkg::REG_LOOK_Z: look_z_reg <= cfg_data;
                ocs_pkg::REG_START_RAD:
                begin
                    start_rad_reg <= cfg_data[RB-1:0];
                    radius_reg    <= clamp_rad(50'($signed({2'b00, cfg_data[RB-1:0]})));
                end
                ocs_pkg::REG_START_AZI:
                begin
                    start_azi_reg <= cfg_data[ANGLE_BITS-1:0];
                    azi_reg       <= cfg_data[ANGLE_BITS-1:0];
                end
                ocs_pkg::REG_START_ELEV:
                begin
                    start_elev_reg <= cfg_data[EB-1:0];
                    elev_reg       <= clamp_elev(elev_cfg);
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.load_item)
        begin
            if (!in_item.op)
            begin
                azi_reg  <= azi_reg + ANGLE_BITS'(da_r);
                elev_reg <= clamp_elev(elev_sum);
            end
            else
            begin
                radius_reg <= clamp_rad(rad_diff);
            end
        end
    end

    assign cfg_rdata_look_x = look_x_reg;
    assign cfg_rdata_look_y = look_y_reg;
    assign cfg_rdata_look_z = look_z_reg;
    assign cfg_rdata_rad    = 32'(start_rad_reg);
    assign cfg_rdata_azi    = 32'(start_azi_reg);
    assign cfg_rdata_elev   = 32'(start_elev_reg);

    // CORDIC angles on a 2^32-per-turn scale.
    logic [31:0] ang_a, ang_e;
    assign ang_a = {azi_reg, {ASH{1'b0}}};
    assign ang_e = 32'({elev_reg[ANGLE_BITS-1:0], {ASH{1'b0}}});

    logic signed [33:0] ax_reg, ay_reg, ex_reg, ey_reg;
    logic signed [32:0] az_reg, ez_reg;
    logic a_flip_reg, e_flip_reg;
    logic [ocs_pkg::ITER_BITS-1:0] it_reg;

    function automatic logic flip_of(input logic [31:0] a);
        logic [31:0] t;
        begin
            t = a + 32'h40000000;
            return t[31];
        end
    endfunction

    logic [31:0] ang_a_f, ang_e_f;
    assign ang_a_f = flip_of(ang_a) ? ang_a + 32'h80000000 : ang_a;
    assign ang_e_f = flip_of(ang_e) ? ang_e + 32'h80000000 : ang_e;

    logic signed [32:0] atn;
    assign atn = $signed({3'b000, ocs_pkg::atan_entry(it_reg)});

    // Iterative rotation, one micro-rotation per cycle on both angles.
    always_ff @(posedge clk)
    begin
        if (cmd.cordic_init)
        begin
            ax_reg     <= ocs_pkg::CORDIC_GAIN_Q30;
            ay_reg     <= '0;
            ex_reg     <= ocs_pkg::CORDIC_GAIN_Q30;
            ey_reg     <= '0;
            az_reg     <= $signed({ang_a_f[31], ang_a_f});
            ez_reg     <= $signed({ang_e_f[31], ang_e_f});
            a_flip_reg <= flip_of(ang_a);
            e_flip_reg <= flip_of(ang_e);
            it_reg     <= '0;
        end
        else if (cmd.cordic_step)
        begin
            if (!az_reg[32])
            begin
                ax_reg <= ax_reg - (ay_reg >>> it_reg);
                ay_reg <= ay_reg + (ax_reg >>> it_reg);
                az_reg <= az_reg - atn;
            end
            else
            begin
                ax_reg <= ax_reg + (ay_reg >>> it_reg);
                ay_reg <= ay_reg - (ax_reg >>> it_reg);
                az_reg <= az_reg + atn;
            end
            if (!ez_reg[32])
            begin
                ex_reg <= ex_reg - (ey_reg >>> it_reg);
                ey_reg <= ey_reg + (ex_reg >>> it_reg);
                ez_reg <= ez_reg - atn;
            end
            else
            begin
                ex_reg <= ex_reg + (ey_reg >>> it_reg);
                ey_reg <= ey_reg - (ex_reg >>> it_reg);
                ez_reg <= ez_reg + atn;
            end
            it_reg <= it_reg + 1'b1;
        end
    end

    logic signed [33:0] ca, sa, ce, se;
    assign ca = a_flip_reg ? -ax_reg : ax_reg;
    assign sa = a_flip_reg ? -ay_reg : ay_reg;
    assign ce = e_flip_reg ? -ex_reg : ex_reg;
    assign se = e_flip_reg ? -ey_reg : ey_reg;

    // First multiply stage: radius times elevation terms.
    localparam logic signed [63:0] HALF30 = 64'sd1 <<< 29;
    logic signed [RB+34:0] rce_p, rse_p;
    logic signed [RB+1:0] rc_reg;
    logic signed [63:0] py_reg;
    assign rce_p = $signed({1'b0, radius_reg}) * ce;
    assign rse_p = $signed({1'b0, radius_reg}) * se;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_rc)
        begin
            rc_reg <= (RB+2)'((64'(rce_p) + HALF30) >>> 30);
            py_reg <= ((64'(rse_p) + HALF30) >>> 30) + 64'(look_y_reg);
        end
    end

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            else if (v < -64'sd2147483648)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

    // Second multiply stage and the output register.
    logic signed [RB+35:0] pxa_p, pza_p;
    logic signed [63:0] px_s, pz_s;
    assign pxa_p = rc_reg * ca;
    assign pza_p = rc_reg * sa;
    assign px_s = ((64'(pxa_p) + HALF30) >>> 30) + 64'(look_x_reg);
    assign pz_s = ((64'(pza_p) + HALF30) >>> 30) + 64'(look_z_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_out)
        begin
            out_item.pos_x <= sat32(px_s);
            out_item.pos_y <= sat32(py_reg);
            out_item.pos_z <= sat32(pz_s);
        end
    end

endmodule

// ----- rtl/orbit_camera_spherical_update.sv -----
// ---------------------------------------------------------------------------
// Orbit camera spherical update
// Turns orbit and zoom pointer steps into a camera position on a sphere.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready, in_data): one orbit or zoom step per
// transaction. Output channel (out_valid/out_ready, out_data): one camera
// position per step, look-at point plus radius times the direction vector.
// An item goes from acceptance to result in order: the accepting edge
// applies the state update, then come one CORDIC set-up, 28 iterations of
// the two CORDIC rotators, run side by side, and two multiply stages. A new
// step is taken only once the previous one has reached the output register.
// If the receiver stalls, the result is held and the next step runs up to
// its final stage, then waits.
// The APB port writes the look-at point and start registers; writing a
// start register loads the matching state at once. Configuration is to be
// written only while the block is idle; the block does not enforce this.
// After reset the look-at point is zero, both angles are zero and the
// radius is 5.0.
// ---------------------------------------------------------------------------
module orbit_camera_spherical_update #(
    parameter int ANGLE_BITS = ocs_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = ocs_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ocs_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ocs_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    ocs_pkg::dp_cmd_t cmd;
    logic cfg_we;
    logic [31:0] r_lx, r_ly, r_lz, r_rad, r_azi, r_elev;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // Register read-back.
    always_comb
    begin
        case (paddr[4:2])
            ocs_pkg::REG_LOOK_X:     prdata = r_lx;
            ocs_pkg::REG_LOOK_Y:     prdata = r_ly;
            ocs_pkg::REG_LOOK_Z:     prdata = r_lz;
            ocs_pkg::REG_START_RAD:  prdata = r_rad;
            ocs_pkg::REG_START_AZI:  prdata = r_azi;
            ocs_pkg::REG_START_ELEV: prdata = r_elev;
            default:                 prdata = '0;
        endcase
    end

    ocs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ocs_datapath #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .in_item          (in_data),
        .cfg_we           (cfg_we),
        .cfg_idx          (paddr[4:2]),
        .cfg_data         (pwdata),
        .cfg_rdata_look_x (r_lx),
        .cfg_rdata_look_y (r_ly),
        .cfg_rdata_look_z (r_lz),
        .cfg_rdata_rad    (r_rad),
        .cfg_rdata_azi    (r_azi),
        .cfg_rdata_elev   (r_elev),
        .out_item         (out_data)
    );

endmodule
